// ===== rtl/mhash_pkg.sv =====
// ----------------------------------------------------------------------------
// mhash_pkg
// Shared constants, command record and helpers for the array hash block.
// ----------------------------------------------------------------------------
package mhash_pkg;

  localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
  localparam int          MIX_SHIFT = 47;

  localparam logic [1:0] EW_8  = 2'd0;
  localparam logic [1:0] EW_16 = 2'd1;

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  // One request's worth of work for the hash chain, executed in field order.
  typedef struct packed {
    logic        init;
    logic [63:0] init_val;
    logic        absorb_a;
    logic [63:0] word_a;
    logic        absorb_b;
    logic [63:0] word_b;
    logic        fin;
  } mhash_cmd_t;

  function automatic logic [63:0] xorshift(input logic [63:0] v);
    return v ^ (v >> MIX_SHIFT);
  endfunction

endpackage

// ===== rtl/mhash_front.sv =====
// ----------------------------------------------------------------------------
// mhash_front
// Packs elements little-endian into 64-bit words and issues hash commands.
// ----------------------------------------------------------------------------
module mhash_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic                 start_req,
  input  logic [31:0]          key_length,
  input  logic [31:0]          element,
  input  logic                 last,
  input  logic [63:0]          seed,
  input  logic [1:0]           elem_width,
  output mhash_pkg::mhash_cmd_t cmd,
  output logic                 cmd_push
);
  import mhash_pkg::*;

  logic [63:0] wb_r;
  logic [2:0]  lane_r;

  logic [3:0]  lanes;
  logic [63:0] elem_x;
  logic [2:0]  lp0, lpa, lpb, lpc;
  logic [63:0] wb0, wba, wbb, wbc;
  logic [63:0] shifted;
  logic        take, pre, post, tail;

  always_comb begin
    unique case (elem_width)
      EW_8: begin
        lanes  = 4'd8;
        elem_x = {56'b0, element[7:0]};
      end
      EW_16: begin
        lanes  = 4'd4;
        elem_x = {48'b0, element[15:0]};
      end
      default: begin
        lanes  = 4'd2;
        elem_x = {32'b0, element};
      end
    endcase

    lp0  = start_req ? 3'd0 : lane_r;
    wb0  = start_req ? 64'd0 : wb_r;
    take = !(start_req && (key_length == 32'd0));

    // width changed while a word was partly packed
    pre = take && ({1'b0, lp0} >= lanes);
    lpa = pre ? 3'd0 : lp0;
    wba = pre ? 64'd0 : wb0;

    unique case (elem_width)
      EW_8:    shifted = elem_x << {lpa, 3'b0};
      EW_16:   shifted = elem_x << {lpa, 4'b0};
      default: shifted = elem_x << {lpa, 5'b0};
    endcase

    wbb  = take ? (wba | shifted) : wba;
    lpb  = take ? lpa + 3'd1 : lpa;
    post = take && ((lpb == 3'd0) || ({1'b0, lpb} >= lanes));
    lpc  = post ? 3'd0 : lpb;
    wbc  = post ? 64'd0 : wbb;
    tail = last && (lpc != 3'd0);

    cmd.init     = start_req;
    cmd.init_val = seed ^ {32'b0, key_length};
    cmd.absorb_a = pre;
    cmd.word_a   = wb0;
    cmd.absorb_b = post || tail;
    cmd.word_b   = post ? wbb : wbc;
    cmd.fin      = last;
    cmd_push     = accept && (start_req || pre || post || tail || last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_r   <= '0;
      lane_r <= '0;
    end else if (accept) begin
      wb_r   <= last ? 64'd0 : wbc;
      lane_r <= last ? 3'd0 : lpc;
    end
  end

endmodule

// ===== rtl/mhash_fifo.sv =====
// ----------------------------------------------------------------------------
// mhash_fifo
// Short command queue between the packing front and the hash back end.
// ----------------------------------------------------------------------------
module mhash_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  mhash_pkg::mhash_cmd_t wr_data,
  output logic                  full,
  input  logic                  rd_en,
  output mhash_pkg::mhash_cmd_t rd_data,
  output logic                  empty
);
  import mhash_pkg::*;

  mhash_cmd_t           mem [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]   wr_ptr_r;
  logic [CMDQ_AW-1:0]   rd_ptr_r;
  logic [CMDQ_CW-1:0]   cnt_r;

  assign full    = (cnt_r == CMDQ_CW'(CMDQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (rd_en) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (wr_en && !rd_en) cnt_r <= cnt_r + 1'b1;
      else if (!wr_en && rd_en) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr_r] <= wr_data;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CMDQ_CW'(CMDQ_DEPTH)) else $error("command queue count overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty && !wr_en |=> empty) else $error("command queue left empty without a write");
`endif

endmodule

// ===== rtl/mhash_mul.sv =====
// ----------------------------------------------------------------------------
// mhash_mul
// Multicycle 64-bit multiply by the mix constant, low 64 bits of the product.
// ----------------------------------------------------------------------------
module mhash_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  output logic        busy,
  output logic        done,
  output logic [63:0] p
);
  import mhash_pkg::*;

  logic [63:0] a_r;
  logic [1:0]  step_r;
  logic        busy_r;
  logic        done_r;
  logic [63:0] prod_r;
  logic [63:0] acc_r;

  logic [31:0] op_a, op_b;
  logic [63:0] mult;

  // lo*lo, then lo*hi and hi*lo cross terms (only their low halves matter)
  assign op_a = (step_r == 2'd2) ? a_r[63:32] : a_r[31:0];
  assign op_b = (step_r == 2'd1) ? MIX_MUL[63:32] : MIX_MUL[31:0];
  assign mult = op_a * op_b;

  assign busy = busy_r;
  assign done = done_r;
  assign p    = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && (step_r == 2'd3);
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd3) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) a_r <= a;
    if (busy_r) begin
      prod_r <= mult;
      unique case (step_r)
        2'd0:    acc_r <= acc_r;
        2'd1:    acc_r <= prod_r;
        default: acc_r <= acc_r + {prod_r[31:0], 32'b0};
      endcase
    end
  end

endmodule

// ===== rtl/mhash_back.sv =====
// ----------------------------------------------------------------------------
// mhash_back
// Runs hash commands: seeds the chain, mixes words, finalizes into result reg.
// ----------------------------------------------------------------------------
module mhash_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_empty,
  input  mhash_pkg::mhash_cmd_t cmd,
  output logic                  cmd_pop,
  input  logic                  pop,
  output logic                  out_valid,
  output logic [63:0]           out_hash
);
  import mhash_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DISP = 3'd1;
  localparam logic [2:0] ST_W1   = 3'd2;
  localparam logic [2:0] ST_W2   = 3'd3;
  localparam logic [2:0] ST_H    = 3'd4;
  localparam logic [2:0] ST_F1   = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0]  st_r, st_nxt;
  logic [63:0] h_r, h_nxt;
  logic [63:0] w_r, w_nxt;
  logic        av_r, av_nxt;
  logic [63:0] aw_r, aw_nxt;
  logic        bv_r, bv_nxt;
  logic [63:0] bw_r, bw_nxt;
  logic        fin_r, fin_nxt;
  logic [63:0] res_r, res_nxt;
  logic        ov_r, ov_nxt;
  logic [63:0] oh_r, oh_nxt;

  logic        mul_start, mul_busy, mul_done;
  logic [63:0] mul_a, mul_p;

  mhash_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .busy  (mul_busy),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_comb begin
    st_nxt    = st_r;
    h_nxt     = h_r;
    w_nxt     = w_r;
    av_nxt    = av_r;
    aw_nxt    = aw_r;
    bv_nxt    = bv_r;
    bw_nxt    = bw_r;
    fin_nxt   = fin_r;
    res_nxt   = res_r;
    ov_nxt    = ov_r;
    oh_nxt    = oh_r;
    mul_start = 1'b0;
    mul_a     = '0;
    cmd_pop   = 1'b0;

    if (ov_r && pop) ov_nxt = 1'b0;

    unique case (st_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          if (cmd.init) h_nxt = cmd.init_val;
          av_nxt  = cmd.absorb_a;
          aw_nxt  = cmd.word_a;
          bv_nxt  = cmd.absorb_b;
          bw_nxt  = cmd.word_b;
          fin_nxt = cmd.fin;
          st_nxt  = ST_DISP;
        end
      end
      ST_DISP: begin
        priority if (av_r) begin
          mul_start = 1'b1;
          mul_a     = aw_r;
          av_nxt    = 1'b0;
          st_nxt    = ST_W1;
        end else if (bv_r) begin
          mul_start = 1'b1;
          mul_a     = bw_r;
          bv_nxt    = 1'b0;
          st_nxt    = ST_W1;
        end else if (fin_r) begin
          mul_start = 1'b1;
          mul_a     = xorshift(h_r);
          st_nxt    = ST_F1;
        end else begin
          st_nxt = ST_IDLE;
        end
      end
      ST_W1: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = xorshift(mul_p);
          st_nxt    = ST_W2;
        end
      end
      ST_W2: begin
        if (mul_done) begin
          w_nxt     = mul_p;
          mul_start = 1'b1;
          mul_a     = h_r;
          st_nxt    = ST_H;
        end
      end
      ST_H: begin
        if (mul_done) begin
          h_nxt  = mul_p ^ w_r;
          st_nxt = ST_DISP;
        end
      end
      ST_F1: begin
        if (mul_done) begin
          res_nxt = xorshift(mul_p);
          st_nxt  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ov_r || pop) begin
          ov_nxt  = 1'b1;
          oh_nxt  = res_r;
          h_nxt   = '0;
          fin_nxt = 1'b0;
          st_nxt  = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      h_r   <= '0;
      av_r  <= 1'b0;
      bv_r  <= 1'b0;
      fin_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      h_r   <= h_nxt;
      av_r  <= av_nxt;
      bv_r  <= bv_nxt;
      fin_r <= fin_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r   <= w_nxt;
    aw_r  <= aw_nxt;
    bw_r  <= bw_nxt;
    res_r <= res_nxt;
    oh_r  <= oh_nxt;
  end

  assign out_valid = ov_r;
  assign out_hash  = oh_r;

`ifndef SYNTHESIS
  a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> !mul_busy) else $error("multiplier restarted while busy");
  a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (st_r == ST_W1 || st_r == ST_W2 || st_r == ST_H || st_r == ST_F1))
    else $error("product arrived with no step waiting");
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(st_r) == ST_OUT) else $error("result shown outside finalize");
`endif

endmodule

// ===== rtl/murmur64a_array_hash.sv =====
// ----------------------------------------------------------------------------
// murmur64a_array_hash
// Streaming MurmurHash64A over 8/16/32-bit integer array keys.
//
// Input queue: push one element per request; the first request of a key has
// in_start_req set and carries the element count in in_key_length, the final
// one has in_last set. full holds off requests while the command queue is full.
// Result queue: one 64-bit hash per key in out_hash_value while empty is low,
// taken with pop. One finished result is held; the back end keeps mixing the
// next key and stalls only when a second result is ready before the pop.
// Packing runs at one element a cycle while the command queue is not full.
// Each full word takes three chained 64-bit multiplies in the back end on a
// shared 32x32 unit, plus fetch and dispatch; finalize adds one more multiply.
// Config: seed at 0x0, element width code at 0x8; write only while idle.
// Reset clears the hash chain, the packing state, both queues and registers.
// ----------------------------------------------------------------------------
module murmur64a_array_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_start_req,
  input  logic [31:0] in_key_length,
  input  logic [31:0] in_element,
  input  logic        in_last,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] out_hash_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import mhash_pkg::*;

  logic [63:0] seed_r;
  logic [1:0]  ew_r;
  logic        cfg_we;

  logic        accept;
  mhash_cmd_t  f_cmd, b_cmd;
  logic        f_push, q_full, q_empty, b_pop, out_valid;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = paddr[3] ? {62'b0, ew_r} : seed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
      ew_r   <= EW_8;
    end else if (cfg_we) begin
      if (paddr[3]) ew_r <= pwdata[1:0];
      else          seed_r <= pwdata;
    end
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  mhash_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .start_req  (in_start_req),
    .key_length (in_key_length),
    .element    (in_element),
    .last       (in_last),
    .seed       (seed_r),
    .elem_width (ew_r),
    .cmd        (f_cmd),
    .cmd_push   (f_push)
  );

  mhash_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (f_push),
    .wr_data (f_cmd),
    .full    (q_full),
    .rd_en   (b_pop),
    .rd_data (b_cmd),
    .empty   (q_empty)
  );

  mhash_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (q_empty),
    .cmd       (b_cmd),
    .cmd_pop   (b_pop),
    .pop       (pop),
    .out_valid (out_valid),
    .out_hash  (out_hash_value)
  );

  assign empty = !out_valid;

endmodule
